>>> rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_in_reg, uer_core and the top level; depends on nothing.
package uer_pkg;

  // Measurement phase, one-hot encoded.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_WAIT_RISE = 4'b0010,
    PH_WAIT_FALL = 4'b0100,
    PH_COMPLETE  = 4'b1000
  } phase_t;

  // Status codes reported with every result.
  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_WAIT_RISE = 2'd1;
  localparam logic [1:0] ST_WAIT_FALL = 2'd2;
  localparam logic [1:0] ST_COMPLETE  = 2'd3;

  // Pulse width in microseconds times 1126/65536 gives centimeters.
  // The product is taken >> 8, which leaves Q8 centimeters.
  localparam logic [10:0] DIST_MUL     = 11'd1126;
  localparam int          DIST_SHIFT   = 8;
  localparam logic [15:0] TIMEOUT_RST  = 16'd60;

  localparam int POLL_W   = 65;
  localparam int RESULT_W = 23;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 24;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] now_us;
    logic        echo_level;
  } poll_t;

  typedef struct packed {
    logic [18:0] distance_q8;
    logic        measured;
    logic [1:0]  status;
    logic        trigger;
  } result_t;

endpackage

>>> rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger.
// Instantiates uer_in_reg and uer_core; depends on uer_pkg.
//
// Each request on the s_ channel is one poll of an HC-SR04 style sensor:
// the sampled echo pin plus free-running microsecond and millisecond times.
// Every poll produces exactly one result request on the m_ channel with
// the trigger request, the phase after the poll, a measured flag and the
// distance in 1/256 cm (zero unless measured is set).
// The cfg_ channel writes the 16-bit timeout in milliseconds; cfg_ready is
// always high, and writes are expected only while no poll is in flight.
// A poll passes two registers: it is taken into the input register, and
// when the core takes it from there, the core computes it and loads the
// result register. Throughput is one poll per clock while m_tready is
// high; the phase update and the 16x11 bit distance multiply sit in the
// single stage between the two registers. When the receiver holds
// m_tready low, the result stays put, the input register still takes one
// more poll if it is empty, and once it holds one s_tready drops.
// Synchronous reset empties both registers, returns the phase to idle,
// clears the stored times and sets the timeout to 60 ms.
module ultrasonic_echo_ranger import uer_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [0] echo_level, [32:1] now_us, [64:33] now_ms, [71:65] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] trigger, [2:1] status, [3] measured, [22:4] distance_q8, [23] zero
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  poll_t   in_poll;
  poll_t   held_poll;
  logic    held_valid;
  logic    held_take;
  result_t result;

  // The zero padding bits of s_tdata above the fields are ignored.
  assign in_poll   = s_tdata[POLL_W-1:0];
  assign cfg_ready = 1'b1;

  uer_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_poll    (in_poll),
    .held_valid (held_valid),
    .held_poll  (held_poll),
    .held_take  (held_take)
  );

  uer_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (held_valid),
    .in_poll    (held_poll),
    .in_take    (held_take),
    .out_valid  (m_tvalid),
    .out_result (result),
    .out_ready  (m_tready)
  );

  assign m_tdata = {1'b0, result};

endmodule

>>> rtl/uer_in_reg.sv
// Input register stage of the ultrasonic echo ranger.
// Holds one poll request until the core takes it; depends on uer_pkg.
module uer_in_reg import uer_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  poll_t in_poll,
  output logic  held_valid,
  output poll_t held_poll,
  input  logic  held_take
);

  logic  valid;
  poll_t poll;

  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_poll  = poll;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll <= in_poll;
    end
  end

endmodule

>>> rtl/uer_core.sv
// Ranging core: phase state, timeout register, distance arithmetic and
// the result register. Depends on uer_pkg.
module uer_core import uer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  poll_t       in_poll,
  output logic        in_take,
  output logic        out_valid,
  output result_t     out_result,
  input  logic        out_ready
);

  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] trigger_time_ms;
  logic [31:0] trigger_time_next;
  logic [31:0] echo_rise_us;
  logic [31:0] echo_rise_next;
  logic [15:0] timeout_ms;
  logic        trig;
  logic        meas;
  logic [15:0] width;
  logic [26:0] product;
  logic [18:0] distance;
  logic [31:0] elapsed;
  logic [1:0]  status;
  logic        valid;
  result_t     result;

  assign in_take = in_valid && (!valid || out_ready);

  always_comb begin
    trig              = 1'b0;
    meas              = 1'b0;
    phase_next        = phase;
    trigger_time_next = trigger_time_ms;
    echo_rise_next    = echo_rise_us;
    width             = in_poll.now_us[15:0] - echo_rise_us[15:0];
    product           = 27'(width) * 27'(DIST_MUL);
    unique case (phase) inside
      PH_IDLE, PH_COMPLETE: begin
        trig              = 1'b1;
        trigger_time_next = in_poll.now_ms;
        phase_next        = PH_WAIT_RISE;
      end
      PH_WAIT_RISE: begin
        if (in_poll.echo_level) begin
          echo_rise_next = in_poll.now_us;
          phase_next     = PH_WAIT_FALL;
        end
      end
      PH_WAIT_FALL: begin
        if (!in_poll.echo_level) begin
          meas       = 1'b1;
          phase_next = PH_COMPLETE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    distance = meas ? product[DIST_SHIFT +: 19] : 19'd0;
    // The timeout counts from the trigger time as updated by this poll.
    elapsed = in_poll.now_ms - trigger_time_next;
    if (elapsed >= {16'd0, timeout_ms}) begin
      phase_next = PH_IDLE;
    end
    unique case (phase_next)
      PH_IDLE:      status = ST_IDLE;
      PH_WAIT_RISE: status = ST_WAIT_RISE;
      PH_WAIT_FALL: status = ST_WAIT_FALL;
      PH_COMPLETE:  status = ST_COMPLETE;
      default:      status = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      trigger_time_ms <= 32'd0;
      echo_rise_us    <= 32'd0;
      timeout_ms      <= TIMEOUT_RST;
      valid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_ms <= cfg_data;
      end
      if (in_take) begin
        phase           <= phase_next;
        trigger_time_ms <= trigger_time_next;
        echo_rise_us    <= echo_rise_next;
        valid           <= 1'b1;
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      result.trigger     <= trig;
      result.status      <= status;
      result.measured    <= meas;
      result.distance_q8 <= distance;
    end
  end

  assign out_valid  = valid;
  assign out_result = result;

  a_meas_status: assert property (@(posedge clk) disable iff (rst)
    valid && result.measured |-> result.status == ST_COMPLETE || result.status == ST_IDLE)
    else $error("measurement reported with a wrong status");

  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !result.measured |-> result.distance_q8 == 19'd0)
    else $error("distance not zero without a measurement");

  a_trig_status: assert property (@(posedge clk) disable iff (rst)
    valid && result.trigger |-> result.status == ST_WAIT_RISE || result.status == ST_IDLE)
    else $error("trigger reported with a wrong status");

  a_no_trig_meas: assert property (@(posedge clk) disable iff (rst)
    valid |-> !(result.trigger && result.measured))
    else $error("trigger and measurement in one poll");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> phase == PH_IDLE && !valid)
    else $error("core not idle after reset");

endmodule

>>> tb/ranger_checker.sv
`timescale 1ns / 1ps
// Checker for the ultrasonic echo ranger: watches the poll, result and timeout channels,
// predicts every result from its own copy of the ranging state and compares it.
// Depends on uer_pkg for the poll and result layouts and the status codes.
module ranger_checker import uer_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // [0] echo_level, [32:1] now_us, [64:33] now_ms, [71:65] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // [0] trigger, [2:1] status, [3] measured, [22:4] distance_q8, [23] zero
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  outstanding
);

  logic [1:0]  range_phase;
  logic [31:0] trigger_ms;
  logic [31:0] rise_us;
  logic [15:0] timeout_ms;
  result_t     echo_reports[$];
  result_t     got_report;
  result_t     want_report;
  int          bad_results;
  int          shown;

  // One poll of the sensor: phase update first, then the timeout from the trigger.
  function automatic result_t predict_poll(poll_t p);
    result_t     r;
    logic [15:0] width_us;
    logic [26:0] product;
    logic [31:0] since_trigger;
    r = '0;
    case (range_phase) inside
      ST_IDLE, ST_COMPLETE: begin
        r.trigger   = 1'b1;
        trigger_ms  = p.now_ms;
        range_phase = ST_WAIT_RISE;
      end
      ST_WAIT_RISE: begin
        if (p.echo_level) begin
          rise_us     = p.now_us;
          range_phase = ST_WAIT_FALL;
        end
      end
      default: begin
        if (!p.echo_level) begin
          width_us      = p.now_us[15:0] - rise_us[15:0];
          product       = 27'(width_us) * 27'(DIST_MUL);
          r.distance_q8 = 19'(product >> DIST_SHIFT);
          r.measured    = 1'b1;
          range_phase   = ST_COMPLETE;
        end
      end
    endcase
    since_trigger = p.now_ms - trigger_ms;
    if (since_trigger >= 32'(timeout_ms)) begin
      range_phase = ST_IDLE;
    end
    r.status = range_phase;
    return r;
  endfunction

  function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) begin
      return 1'b0;
    end
    if (shown < 10) begin
      $display("%0t: result field %s mismatch: expected %0d, got %0d", $time, name, want, got);
      shown++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      range_phase = ST_IDLE;
      trigger_ms  = '0;
      rise_us     = '0;
      timeout_ms  = TIMEOUT_RST;
      echo_reports.delete();
      bad_results = 0;
      shown       = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ms = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got_report = result_t'(m_tdata[RESULT_W-1:0]);
        if (echo_reports.size() == 0) begin
          if (shown < 10) begin
            $display("%0t: result %h arrived with no poll waiting for it", $time, got_report);
            shown++;
          end
          bad_results++;
        end else begin
          want_report = echo_reports.pop_front();
          // Evaluate every field so that each wrong one is reported.
          if (field_differs("trigger", 32'(want_report.trigger), 32'(got_report.trigger)) |
              field_differs("status", 32'(want_report.status), 32'(got_report.status)) |
              field_differs("measured", 32'(want_report.measured), 32'(got_report.measured)) |
              field_differs("distance_q8", 32'(want_report.distance_q8),
                            32'(got_report.distance_q8))) begin
            bad_results++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        echo_reports.push_back(predict_poll(poll_t'(s_tdata[POLL_W-1:0])));
      end
      fail_count  <= bad_results;
      outstanding <= echo_reports.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the ultrasonic echo ranger testbench: clock, reset, poll stimulus, result stalls
// and the verdict. Depends on uer_pkg, ranger_checker and the ultrasonic_echo_ranger RTL.
module tb_top;
  import uer_pkg::*;

  // A long receiver hold-off plus ordinary stalls stay far below this many quiet cycles.
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data  = '0;

  int fail_count;
  int outstanding;
  int quiet_cycles;
  int hold_asks  = 0;
  int hold_done  = 0;
  int burst_left = 0;
  int polls_sent = 0;

  // Free-running sensor clocks that the well-formed ranging sequences walk forward.
  logic [31:0] clock_us;
  logic [31:0] clock_ms;

  always #10 clk = ~clk;

  ultrasonic_echo_ranger i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ranger_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // The watchdog ends the run when no request of any channel has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. The stall pattern rotates between always ready, a coin toss, mostly
  // stalled and strict alternation, so stalls land on every phase of the two-stage
  // pipeline. A hold-off request from the stimulus makes it keep ready low long enough
  // for the block to fill and stall its input.
  initial begin
    int cyc;
    cyc = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_asks != hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        case ((cyc / 97) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(1, 0));
          2:       m_tready <= ($urandom_range(3, 0) == 0);
          default: m_tready <= cyc[0];
        endcase
      end
    end
  end

  // Offers one poll and waits for the edge where it is accepted. Valid stays high
  // across a burst; when the burst runs out it drops for a short random gap. Bursts
  // are sometimes long so that there are stretches without any gap.
  task automatic send_poll(input logic echo, input logic [31:0] now_us,
                           input logic [31:0] now_ms);
    poll_t p;
    p.echo_level = echo;
    p.now_us     = now_us;
    p.now_ms     = now_ms;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - POLL_W){1'b0}}, p};
    do @(posedge clk); while (!s_tready);
    polls_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
    end
  endtask

  // Stops offering and waits until every poll has had its result accepted. Every poll
  // yields one result, so an empty expectation store means the block is idle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Moves the sensor clocks on. The millisecond clock mostly creeps, but now and then
  // jumps far enough to run into the timeout in the middle of a measurement.
  task automatic advance_clocks(input int us_max);
    clock_us += $urandom_range(us_max, 0);
    if ($urandom_range(29, 0) == 0) begin
      clock_ms += $urandom_range(300, 50);
    end else begin
      clock_ms += $urandom_range(2, 0);
    end
  endtask

  // One well-formed measurement: the trigger poll, a few polls waiting for the echo,
  // the echo high for a while and then its fall. Some echoes are long enough that the
  // width wraps past 16 bits.
  task automatic run_ranging();
    int waits;
    int highs;
    int high_step;
    waits     = $urandom_range(3, 0);
    highs     = $urandom_range(5, 1);
    high_step = ($urandom_range(7, 0) == 0) ? 25000 : 6000;
    send_poll(1'($urandom_range(1, 0)), clock_us, clock_ms);
    advance_clocks(300);
    repeat (waits) begin
      send_poll(1'b0, clock_us, clock_ms);
      advance_clocks(300);
    end
    repeat (highs) begin
      send_poll(1'b1, clock_us, clock_ms);
      advance_clocks(high_step);
    end
    send_poll(1'b0, clock_us, clock_ms);
    advance_clocks(500);
  endtask

  // Polls with every field random: echo glitches, clocks running backwards and
  // sequences broken off in any phase.
  task automatic run_noise();
    repeat ($urandom_range(4, 1)) begin
      send_poll(1'($urandom_range(1, 0)), $urandom(), $urandom());
    end
  endtask

  task automatic run_phase(input logic [15:0] timeout, input int poll_count,
                           input bit near_wrap);
    int stop_at;
    write_timeout(timeout);
    clock_us = $urandom();
    clock_ms = near_wrap ? 32'hFFFF_FF00 + $urandom_range(255, 0) : $urandom();
    stop_at  = polls_sent + poll_count;
    while (polls_sent < stop_at) begin
      if ($urandom_range(6, 0) == 0) begin
        run_noise();
      end else begin
        run_ranging();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset timeout of 60 ms.
    // Widest echo: it rises just below the top of the microsecond clock and the
    // wrapped width comes out at 65535 us, the largest distance.
    send_poll(1'b0, 32'h0000_0000, 32'h0000_0000);
    send_poll(1'b1, 32'hFFFF_FFF0, 32'd10);
    send_poll(1'b1, 32'hFFFF_FFF8, 32'd20);
    send_poll(1'b0, 32'h0000_FFEF, 32'd30);
    // From complete the next poll triggers again, echo high or not; then a zero width.
    send_poll(1'b1, 32'd50, 32'd40);
    send_poll(1'b1, 32'd100, 32'd41);
    send_poll(1'b0, 32'd100, 32'd42);
    // Trigger at the top of the millisecond clock; the timeout across the wrap hits
    // while the echo is still awaited.
    send_poll(1'b0, 32'd200, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd300, 32'd59);
    // The poll that sees the fall also times out: measured, yet the status is idle.
    send_poll(1'b1, 32'hFFFF_FFFF, 32'd100);
    send_poll(1'b1, 32'hFFFF_FFFF, 32'd120);
    send_poll(1'b0, 32'd5000, 32'd160);
    // One millisecond short of the timeout, then the rise and the timeout together.
    send_poll(1'b0, 32'd6000, 32'd300);
    send_poll(1'b0, 32'd6100, 32'd359);
    send_poll(1'b1, 32'd6200, 32'd360);

    // A zero timeout leaves every poll idle, so each one triggers anew.
    write_timeout(16'd0);
    send_poll(1'b1, 32'h0000_0000, 32'h0000_0000);
    send_poll(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd5, 32'd5);

    // Largest timeout: the fall lands exactly on it, then an idle poll triggers.
    write_timeout(16'hFFFF);
    send_poll(1'b0, 32'd1000, 32'd0);
    send_poll(1'b1, 32'd2000, 32'd65534);
    send_poll(1'b0, 32'd42000, 32'd65535);
    send_poll(1'b0, 32'd0, 32'd7);

    // Random part. The first phase starts with a long result hold-off while polls keep
    // coming; every phase change waits for all results before the timeout is written.
    // The hold-off is requested only once the block is empty, so that it overlaps the
    // polls of the next phase rather than the drain before its timeout write.
    drain_results();
    hold_asks <= hold_asks + 1;
    run_phase(16'hFFFF, 300, 1'b0);
    run_phase(16'($urandom_range(150, 1)), 300, 1'b1);
    run_phase(16'd0, 60, 1'b0);
    drain_results();
    hold_asks <= hold_asks + 1;
    run_phase(TIMEOUT_RST, 300, 1'b1);
    run_phase(16'd1, 60, 1'b0);
    run_phase(16'($urandom_range(65535, 0)), 280, 1'b1);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> ultrasonic_echo_ranger.f
rtl/uer_pkg.sv
rtl/uer_in_reg.sv
rtl/uer_core.sv
rtl/ultrasonic_echo_ranger.sv
tb/ranger_checker.sv
tb/tb_top.sv
